FILE: rtl/core/drs_pkg.sv
// ----------------------------------------------------------------------------
// drs_pkg
// shared types and constants of the disk request scheduler
// ----------------------------------------------------------------------------
package drs_pkg;

  localparam int QueueDepth = 16;
  localparam int SlotW      = $clog2(QueueDepth);
  localparam int CountW     = $clog2(QueueDepth + 1);
  localparam int EntryW     = 96;

  typedef logic [1:0] policy_t;
  localparam policy_t POL_FCFS  = 2'd0;
  localparam policy_t POL_SSTF  = 2'd1;
  localparam policy_t POL_LOOK  = 2'd2;
  // unused code, handled as first come first served
  localparam policy_t POL_SPARE = 2'd3;

  localparam logic REQ_ARRIVE   = 1'b0;
  localparam logic REQ_COMPLETE = 1'b1;

  // queue entry as stored in the slot memory
  typedef struct packed {
    logic [15:0] process;
    logic [31:0] address;
    logic [15:0] cylinder;
    logic [15:0] arrival_time;
    logic [15:0] id;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_DONE
  } state_t;

  // per-candidate scan flags
  typedef struct packed {
    logic same_cyl;
    logic in_dir;
    logic [15:0] gap;
  } cand_t;

endpackage

FILE: rtl/core/drs_slot_ram.sv
// ----------------------------------------------------------------------------
// drs_slot_ram
// queue slot memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module drs_slot_ram
  import drs_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [SlotW-1:0] waddr,
  input  entry_t           wdata,
  input  logic [SlotW-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [QueueDepth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/disk_request_scheduler.sv
// ----------------------------------------------------------------------------
// disk_request_scheduler
// arrivals: the result is registered through the done state after the item is
// accepted. completions: one slot read per cycle for the scan, then under look
// the last queued entry moves into the chosen slot, and under fcfs/sstf each slot
// after the chosen one is compacted down. one item at a time, next taken after the result.
// synchronous active-low reset clears count, held request and policy;
// slot memory holds no reset state.
// ----------------------------------------------------------------------------
module disk_request_scheduler (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // req_type[0], new_id[16:1], new_arrival_time[32:17], new_cylinder[48:33],
  // new_address[80:49], new_process[96:81], head_position[112:97],
  // scan_up[113], zero pad to 120
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_valid[0], out_id[16:1], out_arrival_time[32:17], out_cylinder[48:33],
  // out_address[80:49], out_process[96:81], dropped[97], zero pad to 104
  output logic [103:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [1:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  import drs_pkg::*;

  state_t state_r, state_nxt;
  policy_t policy_r;
  logic [CountW-1:0] count_r;
  logic held_valid_r;
  entry_t held_r;
  logic dropped_r;
  logic out_tvalid_r;
  // latched item
  logic up_r;
  logic [15:0] head_r;
  // scan
  logic [CountW-1:0] idx_r;     // slot being requested
  logic rd_pend_r;              // read data valid this cycle
  logic [SlotW-1:0] rd_slot_r;
  logic found_r, best_same_r, best_dir_r;
  logic [SlotW-1:0] best_r;
  logic [15:0] best_dist_r, best_time_r;
  entry_t best_ent_r;
  // move
  logic [CountW-1:0] mv_src_r;

  // ram
  logic ram_we;
  logic [SlotW-1:0] ram_waddr, ram_raddr;
  entry_t ram_wdata, ram_rdata;

  drs_slot_ram u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {30'd0, policy_r};
  wire cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == 2'd0);

  wire in_acc = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE) && !out_tvalid_r;
  assign out_tvalid = out_tvalid_r;

  entry_t in_ent;
  assign in_ent = '{process: in_tdata[96:81], address: in_tdata[80:49],
                    cylinder: in_tdata[48:33], arrival_time: in_tdata[32:17],
                    id: in_tdata[16:1]};

  // candidate evaluation on read data
  cand_t cand;
  logic better;
  always_comb begin
    cand.gap = (ram_rdata.cylinder > head_r) ? ram_rdata.cylinder - head_r
                                             : head_r - ram_rdata.cylinder;
    cand.same_cyl = ram_rdata.cylinder == head_r;
    cand.in_dir = up_r ? (ram_rdata.cylinder > head_r)
                       : (ram_rdata.cylinder < head_r);
    better = 1'b0;
    if (!found_r) begin
      better = 1'b1;
    end else begin
      case (policy_r)
        POL_SSTF: better = (cand.gap < best_dist_r) ||
                           ((cand.gap == best_dist_r) &&
                            (ram_rdata.arrival_time < best_time_r));
        POL_LOOK: begin
          if (cand.same_cyl) begin
            better = !best_same_r || (ram_rdata.arrival_time < best_time_r);
          end else if (best_same_r) begin
            better = 1'b0;
          end else if (cand.in_dir) begin
            better = !best_dir_r || (cand.gap < best_dist_r);
          end else if (best_dir_r) begin
            better = 1'b0;
          end else begin
            better = cand.gap < best_dist_r;
          end
        end
        default: better = ram_rdata.arrival_time < best_time_r;
      endcase
    end
  end

  wire scan_done = !rd_pend_r && (idx_r == count_r);
  wire last_mv = (mv_src_r == count_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tdata[0] == REQ_COMPLETE && count_r != '0) state_nxt = ST_SCAN;
          else state_nxt = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          if (policy_r == POL_LOOK) state_nxt = ST_MOVE_RD;
          else if ({1'b0, best_r} + 1'b1 == count_r) state_nxt = ST_DONE;
          else state_nxt = ST_MOVE_RD;
        end
      end
      ST_MOVE_RD: state_nxt = ST_MOVE_WR;
      ST_MOVE_WR: begin
        if (policy_r == POL_LOOK || last_mv) state_nxt = ST_DONE;
        else state_nxt = ST_MOVE_RD;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    ram_we = 1'b0;
    ram_waddr = count_r[SlotW-1:0];
    ram_wdata = in_ent;
    ram_raddr = idx_r[SlotW-1:0];
    case (state_r)
      ST_IDLE: begin
        ram_we = in_acc && in_tdata[0] == REQ_ARRIVE && held_valid_r &&
                 (count_r < CountW'(QueueDepth));
      end
      // count is already decremented, so it indexes the last queued entry
      ST_MOVE_RD: ram_raddr = (policy_r == POL_LOOK) ?
                              count_r[SlotW-1:0] : mv_src_r[SlotW-1:0];
      ST_MOVE_WR: begin
        ram_we = 1'b1;
        ram_wdata = ram_rdata;
        ram_waddr = (policy_r == POL_LOOK) ? best_r : SlotW'(mv_src_r - 1'b1);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      policy_r <= POL_FCFS;
      count_r <= '0;
      held_valid_r <= 1'b0;
      held_r <= '0;
      out_tvalid_r <= 1'b0;
      dropped_r <= 1'b0;
      rd_pend_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) policy_r <= cfg_pwdata[1:0];
      if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          rd_pend_r <= 1'b0;
          found_r <= 1'b0;
          if (in_acc) begin
            dropped_r <= 1'b0;
            if (in_tdata[0] == REQ_ARRIVE) begin
              if (!held_valid_r) begin
                held_valid_r <= 1'b1;
                held_r <= in_ent;
              end else if (count_r < CountW'(QueueDepth)) begin
                count_r <= count_r + 1'b1;
              end else begin
                dropped_r <= 1'b1;
              end
            end else if (count_r == '0) begin
              held_valid_r <= 1'b0;
              held_r <= '0;
            end
          end
        end
        ST_SCAN: begin
          rd_pend_r <= idx_r != count_r;
          if (rd_pend_r && better) found_r <= 1'b1;
          if (scan_done) begin
            held_valid_r <= 1'b1;
            held_r <= best_ent_r;
            count_r <= count_r - 1'b1;
          end
        end
        ST_DONE: out_tvalid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        head_r <= in_tdata[112:97];
        up_r <= in_tdata[113];
        idx_r <= '0;
      end
      ST_SCAN: begin
        if (idx_r != count_r) idx_r <= idx_r + 1'b1;
        rd_slot_r <= idx_r[SlotW-1:0];
        if (rd_pend_r && better) begin
          best_r <= rd_slot_r;
          best_ent_r <= ram_rdata;
          best_dist_r <= cand.gap;
          best_time_r <= ram_rdata.arrival_time;
          best_same_r <= cand.same_cyl;
          best_dir_r <= cand.in_dir;
        end
        // first compaction source is the slot after the chosen one
        if (rd_pend_r && better) mv_src_r <= {1'b0, rd_slot_r} + 1'b1;
        else mv_src_r <= {1'b0, best_r} + 1'b1;
      end
      ST_MOVE_WR: mv_src_r <= mv_src_r + 1'b1;
      default: ;
    endcase
  end

  // result item fields
  assign out_tdata = {6'd0, dropped_r, held_r.process, held_r.address,
                      held_r.cylinder, held_r.arrival_time, held_r.id,
                      held_valid_r};

endmodule
